>>> rtl/replay_window_filter_top_defines.svh
// ----------------------------------------------------------------------------
// Replay window filter assertion macros
// Shared concurrent assertion forms, clocked on clk, quiet during reset.
// ----------------------------------------------------------------------------
`ifndef REPLAY_WINDOW_FILTER_TOP_DEFINES_SVH
`define REPLAY_WINDOW_FILTER_TOP_DEFINES_SVH

// same-cycle implication
`define RWF_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("replay window filter: same-cycle check failed");

// next-cycle implication
`define RWF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("replay window filter: next-cycle check failed");

`endif

>>> rtl/rwf_pkg.sv
// ----------------------------------------------------------------------------
// Replay window filter package
// Status codes and shared types for the filter cells.
// ----------------------------------------------------------------------------
package rwf_pkg;

    localparam logic [2:0] ST_ACCEPTED  = 3'd0;
    localparam logic [2:0] ST_DUP_EVENT = 3'd1;
    localparam logic [2:0] ST_FULL      = 3'd2;
    localparam logic [2:0] ST_STALE     = 3'd3;
    localparam logic [2:0] ST_DUP_SEQ   = 3'd4;

    typedef struct packed {
        logic [63:0] group_high;
        logic [63:0] group_low;
        logic [63:0] key_word_a;
        logic [63:0] key_word_b;
        logic [63:0] key_word_c;
        logic [63:0] key_word_d;
        logic [31:0] epoch;
        logic [31:0] node_id;
    } sender_id_t;

    // per-cell write command
    typedef struct packed {
        logic clear;
        logic load_id;
        logic load_win;
    } sender_cmd_t;

endpackage

>>> rtl/rwf_event_cell.sv
// ----------------------------------------------------------------------------
// Event ring cell
// Holds one recorded event id and flags a match against the probe.
// ----------------------------------------------------------------------------
module rwf_event_cell (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         clear,
    input  logic         write,
    input  logic [127:0] wr_id,
    input  logic [127:0] probe_id,
    input  logic         hit_in,
    output logic         hit_out
);

    logic         valid_reg;
    logic [127:0] id_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (clear)
        begin
            valid_reg <= 1'b0;
        end
        else if (write)
        begin
            valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (write)
        begin
            id_reg <= wr_id;
        end
    end

    // hit flag ripples along the ring
    assign hit_out = hit_in | (valid_reg && (id_reg == probe_id));

endmodule

>>> rtl/rwf_sender_cell.sv
// ----------------------------------------------------------------------------
// Sender table cell
// Holds one sender identity with its top sequence and seen bitmap.
// ----------------------------------------------------------------------------
module rwf_sender_cell #(
    parameter int WINDOW_BITS = 64
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  rwf_pkg::sender_cmd_t    cmd,
    input  rwf_pkg::sender_id_t     wr_id,
    input  logic [63:0]             wr_top,
    input  logic [WINDOW_BITS-1:0]  wr_bitmap,
    input  rwf_pkg::sender_id_t     probe_id,
    input  logic                    match_in,
    input  logic                    free_in,
    output logic                    match_out,
    output logic                    free_out,
    output logic                    match_first,
    output logic                    free_first,
    output logic [63:0]             top,
    output logic [WINDOW_BITS-1:0]  bitmap
);

    logic                   valid_reg;
    rwf_pkg::sender_id_t    id_reg;
    logic [63:0]            top_reg;
    logic [WINDOW_BITS-1:0] bitmap_reg;
    logic                   match;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (cmd.clear)
        begin
            valid_reg <= 1'b0;
        end
        else if (cmd.load_id)
        begin
            valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_id)
        begin
            id_reg <= wr_id;
        end
        if (cmd.load_win)
        begin
            top_reg    <= wr_top;
            bitmap_reg <= wr_bitmap;
        end
    end

    assign match       = valid_reg && (id_reg == probe_id);
    assign match_first = match && !match_in;
    assign match_out   = match_in | match;
    assign free_first  = !valid_reg && !free_in;
    assign free_out    = free_in | !valid_reg;
    assign top         = top_reg;
    assign bitmap      = bitmap_reg;

endmodule

>>> rtl/replay_window_filter_top.sv
// ----------------------------------------------------------------------------
// Replay window filter top level
// Duplicate-event ring and per-sender sliding sequence window.
// ----------------------------------------------------------------------------
// Use: one message header per input transaction (in_valid/in_ready), one
// status per output transaction (out_valid/out_ready). op=1 clears both
// tables and the ring pointer and reports accepted.
// Flow: the header is compared against every ring cell and sender cell
// in the cycle it is taken and the results are registered; the verdict and
// table update happen on leaving the update state, when the status lands in
// the output register. A new header is taken only in the idle state, after
// the single in-flight header has finished its compare and update.
// Reset: all cells invalid, ring pointer zero, no status pending; nothing
// needs a clearing pass since each cell carries its own valid flag.
// Stall: a status waits in the output register while out_ready is low; a new
// header is still accepted and compared, but its update waits in the update
// state until the output register is free.
// ----------------------------------------------------------------------------
`include "replay_window_filter_top_defines.svh"

module replay_window_filter_top #(
    parameter int SENDER_SLOTS = 8,
    parameter int EVENT_SLOTS  = 32,
    parameter int WINDOW_BITS  = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        op,
    input  logic [63:0] event_id_high,
    input  logic [63:0] event_id_low,
    input  logic [63:0] group_high,
    input  logic [63:0] group_low,
    input  logic [63:0] key_word_a,
    input  logic [63:0] key_word_b,
    input  logic [63:0] key_word_c,
    input  logic [63:0] key_word_d,
    input  logic [31:0] epoch,
    input  logic [31:0] node_id,
    input  logic [63:0] sequence_req,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  status
);

    localparam int PTRW = (EVENT_SLOTS > 1) ? $clog2(EVENT_SLOTS) : 1;
    localparam logic [PTRW-1:0] PTR_LAST = PTRW'(EVENT_SLOTS - 1);

    localparam logic S_IDLE   = 1'b0;
    localparam logic S_UPDATE = 1'b1;

    logic state_reg, state_next;
    logic accept, commit;

    // header captured at accept
    logic                  op_reg;
    logic [127:0]          ev_reg;
    rwf_pkg::sender_id_t   id_reg;
    logic [63:0]           seq_reg;

    // compare results captured at accept
    logic                    dup_reg;
    logic                    found_reg;
    logic                    free_reg;
    logic [SENDER_SLOTS-1:0] found_vec_reg;
    logic [SENDER_SLOTS-1:0] free_vec_reg;

    logic [PTRW-1:0] ptr_reg, ptr_next;
    logic            out_valid_reg;
    logic [2:0]      status_reg;

    rwf_pkg::sender_id_t probe_id;
    logic [127:0]        probe_ev;

    // chains
    logic [EVENT_SLOTS:0]    ev_hit_chain;
    logic [SENDER_SLOTS:0]   match_chain;
    logic [SENDER_SLOTS:0]   free_chain;
    logic [SENDER_SLOTS-1:0] match_first;
    logic [SENDER_SLOTS-1:0] free_first;
    logic [63:0]             cell_top    [SENDER_SLOTS];
    logic [WINDOW_BITS-1:0]  cell_bitmap [SENDER_SLOTS];

    // update datapath
    logic [63:0]            sel_top;
    logic [WINDOW_BITS-1:0] sel_bitmap;
    logic [63:0]            adv, age;
    logic                   ahead, seen;
    logic [WINDOW_BITS-1:0] age_bit;
    logic [63:0]            wr_top;
    logic [WINDOW_BITS-1:0] wr_bitmap;
    logic                   do_alloc, do_win, do_store;
    logic [2:0]             status_next;

    assign accept   = in_valid && in_ready;
    assign in_ready = (state_reg == S_IDLE);
    assign commit   = (state_reg == S_UPDATE) && (!out_valid_reg || out_ready);

    assign probe_ev = {event_id_high, event_id_low};
    assign probe_id = '{group_high, group_low, key_word_a, key_word_b,
                        key_word_c, key_word_d, epoch, node_id};

    assign ev_hit_chain[0] = 1'b0;
    assign match_chain[0]  = 1'b0;
    assign free_chain[0]   = 1'b0;

    for (genvar e = 0; e < EVENT_SLOTS; e++)
    begin : g_event
        rwf_event_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .clear    (commit && op_reg),
            .write    (commit && !op_reg && do_store && (ptr_reg == PTRW'(e))),
            .wr_id    (ev_reg),
            .probe_id (probe_ev),
            .hit_in   (ev_hit_chain[e]),
            .hit_out  (ev_hit_chain[e+1])
        );
    end

    for (genvar s = 0; s < SENDER_SLOTS; s++)
    begin : g_sender
        rwf_pkg::sender_cmd_t cmd;
        assign cmd.clear    = commit && op_reg;
        assign cmd.load_id  = commit && !op_reg && do_alloc && free_vec_reg[s];
        assign cmd.load_win = commit && !op_reg &&
                              ((do_alloc && free_vec_reg[s]) || (do_win && found_vec_reg[s]));
        rwf_sender_cell #(.WINDOW_BITS(WINDOW_BITS)) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .cmd         (cmd),
            .wr_id       (id_reg),
            .wr_top      (wr_top),
            .wr_bitmap   (wr_bitmap),
            .probe_id    (probe_id),
            .match_in    (match_chain[s]),
            .free_in     (free_chain[s]),
            .match_out   (match_chain[s+1]),
            .free_out    (free_chain[s+1]),
            .match_first (match_first[s]),
            .free_first  (free_first[s]),
            .top         (cell_top[s]),
            .bitmap      (cell_bitmap[s])
        );
    end

    // select the matched sender's window (one-hot AND-OR)
    always_comb
    begin
        sel_top    = '0;
        sel_bitmap = '0;
        for (int i = 0; i < SENDER_SLOTS; i++)
        begin
            if (found_vec_reg[i])
            begin
                sel_top    = sel_top | cell_top[i];
                sel_bitmap = sel_bitmap | cell_bitmap[i];
            end
        end
    end

    assign ahead   = seq_reg > sel_top;
    assign adv     = seq_reg - sel_top;
    assign age     = sel_top - seq_reg;
    assign age_bit = {{(WINDOW_BITS-1){1'b0}}, 1'b1} << age;
    assign seen    = |(sel_bitmap & age_bit);

    always_comb
    begin
        do_alloc    = 1'b0;
        do_win      = 1'b0;
        wr_top      = seq_reg;
        wr_bitmap   = {{(WINDOW_BITS-1){1'b0}}, 1'b1};
        status_next = rwf_pkg::ST_ACCEPTED;
        if (dup_reg)
        begin
            status_next = rwf_pkg::ST_DUP_EVENT;
        end
        else if (!found_reg)
        begin
            if (free_reg)
            begin
                do_alloc = 1'b1;
            end
            else
            begin
                status_next = rwf_pkg::ST_FULL;
            end
        end
        else if (ahead)
        begin
            do_win = 1'b1;
            if (adv < 64'(WINDOW_BITS))
            begin
                wr_bitmap = (sel_bitmap << adv) | {{(WINDOW_BITS-1){1'b0}}, 1'b1};
            end
        end
        else if (age >= 64'(WINDOW_BITS))
        begin
            status_next = rwf_pkg::ST_STALE;
        end
        else if (seen)
        begin
            status_next = rwf_pkg::ST_DUP_SEQ;
        end
        else
        begin
            do_win    = 1'b1;
            wr_top    = sel_top;
            wr_bitmap = sel_bitmap | age_bit;
        end
        if (op_reg)
        begin
            status_next = rwf_pkg::ST_ACCEPTED;
        end
    end

    assign do_store = do_alloc || do_win;

    always_comb
    begin
        ptr_next = ptr_reg;
        if (commit)
        begin
            if (op_reg)
            begin
                ptr_next = '0;
            end
            else if (do_store)
            begin
                ptr_next = (ptr_reg == PTR_LAST) ? '0 : ptr_reg + 1'b1;
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:   if (accept) state_next = S_UPDATE;
            S_UPDATE: if (commit) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ptr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ptr_reg   <= ptr_next;
            if (commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg        <= op;
            ev_reg        <= probe_ev;
            id_reg        <= probe_id;
            seq_reg       <= sequence_req;
            dup_reg       <= ev_hit_chain[EVENT_SLOTS];
            found_reg     <= match_chain[SENDER_SLOTS];
            free_reg      <= free_chain[SENDER_SLOTS];
            found_vec_reg <= match_first;
            free_vec_reg  <= free_first;
        end
        if (commit)
        begin
            status_reg <= status_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;

    // assertions
    `RWF_ASSERT_NEXT(a_accept_to_update, accept, state_reg == S_UPDATE)
    `RWF_ASSERT_SAME(a_found_onehot, state_reg == S_UPDATE, $onehot0(found_vec_reg))
    `RWF_ASSERT_SAME(a_out_after_commit, $rose(out_valid_reg), $past(state_reg == S_UPDATE))

endmodule
